[sv/radix_integer_to_digits_unit_macros.svh]
// Assertion macros for the radix digit converter RTL.
`ifndef RADIX_INTEGER_TO_DIGITS_UNIT_MACROS_SVH
`define RADIX_INTEGER_TO_DIGITS_UNIT_MACROS_SVH

// Clocked check, ignored while reset is high.
`define RID_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RID_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rid_pkg.sv]
// Shared types and constants for the radix digit converter.
package rid_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 6;
  localparam int SIZE_W      = 7;
  localparam int RADIX_W     = 5;
  localparam int REM_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int DIGIT_STEPS = 4;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 8'h30;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RST  = 5'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/rid_div.sv]
// Iterative small-radix divider: four restoring steps per cycle.
module rid_div
  import rid_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   dividend,
  input  logic [RADIX_W-1:0] divisor,
  output logic [WIDTH-1:0]   quotient,
  output logic [REM_W-1:0]   remainder,
  output div_stat_t          stat
);

  localparam int CYC   = WIDTH / DIGIT_STEPS;
  localparam int CNT_W = $clog2(CYC + 1);

  logic [WIDTH-1:0] q;
  logic [WIDTH-1:0] q_next;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_next;
  logic [CNT_W-1:0] cnt;
  logic             done;

  // Four dependent restoring steps on a 5-bit partial remainder
  always_comb begin
    logic [RADIX_W-1:0]     r;
    logic [DIGIT_STEPS-1:0] qb;
    r  = {1'b0, rem};
    qb = '0;
    for (int k = 0; k < DIGIT_STEPS; k++) begin
      r = {r[REM_W-1:0], q[WIDTH-1-k]};
      if (r >= divisor) begin
        r = r - divisor;
        qb[DIGIT_STEPS-1-k] = 1'b1;
      end
    end
    rem_next = r[REM_W-1:0];
    q_next   = {q[WIDTH-DIGIT_STEPS-1:0], qb};
  end

  // Datapath: dividend bits shift out the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      q   <= q_next;
      rem <= rem_next;
    end
  end

  // Step counter and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1)) && !start;
      if (start) begin
        cnt <= CNT_W'(CYC);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  assign quotient   = q;
  assign remainder  = rem;
  assign stat.busy  = (cnt != '0);
  assign stat.done  = done;

endmodule

[sv/radix_integer_to_digits_unit.sv]
// Radix digit converter top level: sequencer, config registers, output register.
// Each digit passes through the divider, is captured as the pending digit and is then emitted to the output register.
// An item produces up to 64 digits.
// A zero value or an empty field skips the divider; one item at a time.
// The single divider retires four quotient bits per cycle and sets the digit rate while the output is not stalled.
// Synchronous reset sets radix to 10, clears the character table and idles the block.
module radix_integer_to_digits_unit
  import rid_pkg::*;
#(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_FIELD   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  is_signed,
  input  logic [SIZE_W-1:0]     field_size,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     digit_char,
  output logic [POS_W-1:0]      position,
  output logic                  last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data
);

`include "radix_integer_to_digits_unit_macros.svh"

  localparam int DW = ((VALUE_WIDTH + DIGIT_STEPS - 1) / DIGIT_STEPS) * DIGIT_STEPS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state;
  logic [RADIX_W-1:0]     radix;
  logic [VALUE_BITS-1:0]  chars_low;
  logic [VALUE_BITS-1:0]  chars_high;
  logic [VALUE_WIDTH-1:0] quot;
  logic [POS_W-1:0]       pos;
  logic [CHAR_W-1:0]      pend_char;
  logic                   pend_last;

  logic [RADIX_W-1:0]     base;
  logic [SIZE_W-1:0]      size_c;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   accept;
  logic                   load;
  logic                   div_start;
  logic [DW-1:0]          div_dividend;
  logic [DW-1:0]          div_quot;
  logic [REM_W-1:0]       div_rem;
  div_stat_t              div_stat;
  logic [VALUE_BITS-1:0]  char_word;
  logic [CHAR_W-1:0]      rem_char;
  logic                   quot_zero;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= RADIX_RST;
      chars_low  <= '0;
      chars_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:      radix      <= cfg_data[RADIX_W-1:0];
        REG_CHARS_LOW:  chars_low  <= cfg_data;
        REG_CHARS_HIGH: chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp radix and field size; take the magnitude of the value
  always_comb begin
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
    size_c = (field_size > SIZE_W'(MAX_FIELD)) ? SIZE_W'(MAX_FIELD) : field_size;
    v      = value[VALUE_WIDTH-1:0];
    mag    = (is_signed && v[VALUE_WIDTH-1]) ? (~v + VALUE_WIDTH'(1)) : v;
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Divider start: new nonzero item with a nonempty field, or next digit once this one is loaded
  assign div_start = (accept && (size_c != '0) && (mag != '0))
                  || (load && !pend_last);
  assign div_dividend = (state == ST_IDLE) ? DW'(mag) : DW'(quot);

  rid_div #(
    .WIDTH (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // Character table lookup for the remainder
  assign char_word = div_rem[REM_W-1] ? chars_high : chars_low;
  assign rem_char  = char_word[div_rem[REM_W-2:0]*CHAR_W +: CHAR_W];
  assign quot_zero = (div_quot[VALUE_WIDTH-1:0] == '0);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (size_c != '0)) begin
            state <= (mag == '0) ? ST_EMIT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            state <= pend_last ? ST_IDLE : ST_DIV;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working registers: running quotient, position, pending digit
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      quot      <= mag;
      pos       <= (mag == '0) ? '0 : POS_W'(size_c - SIZE_W'(1));
      pend_char <= ASCII_ZERO;
      pend_last <= 1'b1;
    end else if (state == ST_DIV && div_stat.done) begin
      quot      <= div_quot[VALUE_WIDTH-1:0];
      pend_char <= rem_char;
      pend_last <= quot_zero || (pos == '0);
    end else if (load && !pend_last) begin
      pos <= pos - POS_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digit_char <= pend_char;
      position   <= pos;
      last       <= pend_last;
    end
  end

  `RID_ASSERT_CLK(a_div_idle_on_start, clk, rst, div_start |-> !div_stat.busy, "divider restarted while busy")
  `RID_ASSERT_CLK(a_done_in_div, clk, rst, div_stat.done |-> (state == ST_DIV), "divider finished outside the divide state")
  `RID_ASSERT_CLK(a_pos_steps_down, clk, rst, (load && !pend_last) |=> (pos == $past(pos) - POS_W'(1)), "position did not count down")
  `RID_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (state == ST_IDLE && !out_valid), "block not idle after reset")

endmodule

[bench/radix_integer_to_digits_unit_tb.sv]
// Testbench for the radix digit converter: directed corners, then random phases with idling.
`timescale 1ns / 100ps

module radix_integer_to_digits_unit_tb;
  import rid_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int          SETTLE_CYCLES = 1200;
  localparam int          FIELD_MAX     = 64;
  localparam int          PHASE_COUNT   = 8;
  localparam int          PHASE_ITEMS   = 50;
  // "0123456789ABCDEF" as the character table
  localparam logic [VALUE_BITS-1:0] HEX_CHARS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [VALUE_BITS-1:0] HEX_CHARS_HIGH = 64'h4645_4443_4241_3938;
  localparam logic [VALUE_BITS-1:0] MOST_NEGATIVE  = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] MOST_POSITIVE  = {1'b0, {(VALUE_BITS-1){1'b1}}};

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              last;
  } digit_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] value      = '0;
  logic                  is_signed  = 1'b0;
  logic [SIZE_W-1:0]     field_size = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [CHAR_W-1:0]     digit_char;
  logic [POS_W-1:0]      position;
  logic                  last;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_RADIX;
  logic [VALUE_BITS-1:0] cfg_data   = '0;

  // Local copy of the register file
  logic [RADIX_W-1:0]    radix_reg  = RADIX_RST;
  logic [VALUE_BITS-1:0] chars_low  = '0;
  logic [VALUE_BITS-1:0] chars_high = '0;

  digit_t      expected_digits[$];
  int          error_count    = 0;
  int          items_sent     = 0;
  int          digits_checked = 0;
  int          settings_used  = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  radix_integer_to_digits_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .is_signed  (is_signed),
    .field_size (field_size),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .position   (position),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("radix_integer_to_digits_unit_tb: done, errors");
      $finish;
    end
  end

  // Random back-pressure on the result side
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each accepted digit with the oldest expected one
  always @(posedge clk) begin : check_digit
    digit_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_digits.size() == 0) begin
        $error("unexpected digit: char %h position %0d last %b", digit_char, position, last);
        error_count++;
      end else begin
        want = expected_digits.pop_front();
        digits_checked++;
        if (digit_char !== want.ch) begin
          $error("digit_char mismatch: expected %h, got %h", want.ch, digit_char);
          error_count++;
        end
        if (position !== want.pos) begin
          $error("position mismatch: expected %0d, got %0d", want.pos, position);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %b, got %b", want.last, last);
          error_count++;
        end
      end
    end
  end

  // Character for one digit from the two table words
  function automatic logic [CHAR_W-1:0] char_for(input logic [VALUE_BITS-1:0] digit);
    logic [VALUE_BITS-1:0] word;
    word = (digit < 8) ? chars_low : chars_high;
    return word[digit[2:0]*8 +: CHAR_W];
  endfunction

  // Work out the digits one number produces and queue them
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] v, input logic sgn,
                                         input logic [SIZE_W-1:0] size);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] base;
    logic [CHAR_W-1:0]     chs[FIELD_MAX];
    logic [POS_W-1:0]      poss[FIELD_MAX];
    digit_t                d;
    int                    width;
    int                    p;
    int                    n;
    base  = VALUE_BITS'((radix_reg < RADIX_MIN) ? RADIX_MIN :
                        (radix_reg > RADIX_MAX) ? RADIX_MAX : radix_reg);
    width = (size > FIELD_MAX) ? FIELD_MAX : int'(size);
    if (width == 0) return;
    mag = (sgn && v[VALUE_BITS-1]) ? (~v + 1'b1) : v;
    // zero is a fixed '0' at position 0
    if (mag == '0) begin
      d.ch   = ASCII_ZERO;
      d.pos  = '0;
      d.last = 1'b1;
      expected_digits.push_back(d);
      return;
    end
    // least significant first; digits past position 0 are dropped
    p = width - 1;
    n = 0;
    while (mag >= base) begin
      if (p >= 0) begin
        chs[n]  = char_for(mag % base);
        poss[n] = p[POS_W-1:0];
        n++;
      end
      p--;
      mag = mag / base;
    end
    if (p >= 0) begin
      chs[n]  = char_for(mag);
      poss[n] = p[POS_W-1:0];
      n++;
    end
    for (int i = 0; i < n; i++) begin
      d.ch   = chs[i];
      d.pos  = poss[i];
      d.last = (i == n - 1);
      expected_digits.push_back(d);
    end
  endfunction

  // Offer one number, wait for it to be taken, then predict its digits
  task automatic send_number(input logic [VALUE_BITS-1:0] v, input logic sgn,
                             input logic [SIZE_W-1:0] size);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    value      = v;
    is_signed  = sgn;
    field_size = size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digits(v, sgn, size);
    items_sent++;
  endtask

  // Stop sending, let every expected digit arrive, then let the block go quiet
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [VALUE_BITS-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_RADIX:      radix_reg  = data[RADIX_W-1:0];
      REG_CHARS_LOW:  chars_low  = data;
      REG_CHARS_HIGH: chars_high = data;
      default: ;
    endcase
  endtask

  // Full register update, only once the block is idle
  task automatic configure(input logic [VALUE_BITS-1:0] radix_val,
                           input logic [VALUE_BITS-1:0] low_val,
                           input logic [VALUE_BITS-1:0] high_val);
    wait_drained();
    set_register(REG_RADIX, radix_val);
    set_register(REG_CHARS_LOW, low_val);
    set_register(REG_CHARS_HIGH, high_val);
    settings_used++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Random number: mixed magnitudes, signs and field sizes
  task automatic send_random_number();
    logic [VALUE_BITS-1:0] v;
    logic                  sgn;
    logic [SIZE_W-1:0]     size;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = v >> $urandom_range(63);
      1: v = v & 64'hFF;
      2: v = ~(v >> $urandom_range(63));
      3: begin
        case ($urandom_range(3))
          0: v = MOST_NEGATIVE;
          1: v = MOST_POSITIVE;
          2: v = '1;
          default: v = '0;
        endcase
      end
      default: ;
    endcase
    sgn = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: size = SIZE_W'($urandom_range(4));
      1: size = SIZE_W'($urandom_range(127, 65));
      default: size = SIZE_W'($urandom_range(64, 1));
    endcase
    send_number(v, sgn, size);
  endtask

  // Reset values: radix 10, all-zero table; zero still gives ASCII '0'
  task automatic test_reset_state();
    send_number(64'd0, 1'b0, 7'd5);
    send_number(64'd123, 1'b0, 7'd3);
  endtask

  // Decimal corners with a readable table
  task automatic test_decimal_corners();
    configure(64'd10, HEX_CHARS_LOW, HEX_CHARS_HIGH);
    send_number(64'd0, 1'b1, 7'd1);
    send_number(64'd77, 1'b0, 7'd0);      // empty field
    send_number('1, 1'b0, 7'd64);         // largest unsigned
    send_number('1, 1'b1, 7'd64);         // minus one
    send_number(MOST_NEGATIVE, 1'b1, 7'd64);
    send_number(MOST_POSITIVE, 1'b1, 7'd20);
    send_number(64'd12345, 1'b0, 7'd3);   // top digits fall off the field
    send_number(64'd12345, 1'b0, 7'd127); // oversized field
    send_number(64'd12345, 1'b0, 7'd65);
    send_number('1, 1'b0, 7'd1);
    send_number(-64'sd42, 1'b1, 7'd4);
    send_number(64'd9, 1'b0, 7'd2);       // single digit
    send_number(64'd10, 1'b1, 7'd2);
  endtask

  // Radix limits and values outside the legal range
  task automatic test_radix_extremes();
    configure(64'd2, HEX_CHARS_LOW, HEX_CHARS_HIGH);
    send_number('1, 1'b0, 7'd64);         // 64 digits
    configure(64'd16, HEX_CHARS_LOW, HEX_CHARS_HIGH);
    send_number(64'hFEDC_BA98_7654_3210, 1'b0, 7'd16);
    send_number(MOST_NEGATIVE, 1'b1, 7'd16);
    configure(64'd0, HEX_CHARS_LOW, HEX_CHARS_HIGH);
    send_number(64'd5, 1'b0, 7'd8);
    configure(64'd1, HEX_CHARS_LOW, HEX_CHARS_HIGH);
    send_number(64'd6, 1'b0, 7'd8);
    configure(64'd17, HEX_CHARS_LOW, HEX_CHARS_HIGH);
    send_number(64'hABCD, 1'b0, 7'd8);
    configure(64'd31, HEX_CHARS_LOW, HEX_CHARS_HIGH);
    send_number(64'h1F, 1'b0, 7'd8);
  endtask

  // Sender holds off until the converter has fully drained
  task automatic test_drain_pause();
    set_idling(58, 58);
    configure(64'd10, HEX_CHARS_LOW, HEX_CHARS_HIGH);
    send_number(64'd987654321, 1'b0, 7'd12);
    wait_drained();
    send_number(-64'sd1000, 1'b1, 7'd6);
    wait_drained();
    send_number(64'd0, 1'b0, 7'd0);
    set_idling(0, 0);
  endtask

  // Random numbers across several radix, table and idling settings
  task automatic test_random_phases();
    logic [VALUE_BITS-1:0] radix_val;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: radix_val = 64'd10;
        1: radix_val = 64'd16;
        2: radix_val = 64'd2;
        3: radix_val = 64'd8;
        4: radix_val = VALUE_BITS'($urandom_range(15, 3));
        5: radix_val = VALUE_BITS'($urandom_range(1) ? $urandom_range(1)
                                                      : $urandom_range(31, 17));
        6: radix_val = VALUE_BITS'($urandom_range(16, 2));
        default: radix_val = VALUE_BITS'($urandom_range(31));
      endcase
      if (ph == 0) configure(radix_val, HEX_CHARS_LOW, HEX_CHARS_HIGH);
      else configure(radix_val, {$urandom, $urandom}, {$urandom, $urandom});
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(58, 0);
        2: set_idling(0, 58);
        default: set_idling(8, 8);
      endcase
      repeat (PHASE_ITEMS) send_random_number();
    end
    set_idling(0, 0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_decimal_corners();
    test_radix_extremes();
    test_drain_pause();
    test_random_phases();
    wait_drained();

    $display("converted %0d numbers into %0d checked digits", items_sent, digits_checked);
    $display("over %0d register settings and four idling patterns", settings_used);
    if (error_count == 0) begin
      $display("radix_integer_to_digits_unit_tb: done, clean");
    end else begin
      $display("radix_integer_to_digits_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/rid_pkg.sv
sv/rid_div.sv
sv/radix_integer_to_digits_unit.sv
bench/radix_integer_to_digits_unit_tb.sv
